/* design/rca_pkg.sv */
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants
// Commands, status codes and default sizes of the handle allocator.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int PoolBytesDefault  = 65536;
  localparam int MaxObjectsDefault = 64;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_RETRIEVE = 2'd1,
    CMD_ADD_REF  = 2'd2,
    CMD_DROP_REF = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NULL      = 3'd4,
    ST_FULL      = 3'd5,
    ST_EXHAUSTED = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] alloc_size;
    logic [31:0] handle;
  } req_t;

  typedef struct packed {
    logic [31:0] new_handle;
    logic [15:0] start_offset;
    logic        buffer_half;
    logic [2:0]  status;
    logic        compacted;
    logic [16:0] freed_before_compaction;
    logic [16:0] bytes_in_use;
    logic [6:0]  object_count;
    logic [15:0] ref_count_now;
  } rsp_t;

endpackage

/* design/rca_if.sv */
// ----------------------------------------------------------------------------
// rca_req_if / rca_rsp_if: valid/ready channels
// Request and response channels of the handle allocator.
// ----------------------------------------------------------------------------
interface rca_req_if;
  import rca_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rca_rsp_if;
  import rca_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/refcounted_compacting_allocator_core.sv */
// ----------------------------------------------------------------------------
// refcounted_compacting_allocator_core: handle allocator with compaction
// Keeps a table of live objects and serves insert, retrieve, add and drop.
// ----------------------------------------------------------------------------
// Usage: one request word on req (command, alloc_size, handle) gives one
// response word on rsp. The block takes one request at a time: req.ready is
// high only while idle. A lookup walks the table through a single compare
// unit, one entry after the other (read, wait for the registered data,
// compare), for retrieve/add/drop. Drop to zero then shifts the tail down.
// Insert that compacts walks every entry with a shared adder. The block
// returns to idle in the cycle after the response is taken. The table is a
// memory with one read and one write port, read data registered. After
// reset (rst, sync, active high) the table is empty and the first handle is
// 1; no clearing pass is needed. The response is held in an output register
// until rsp.ready; a stalled receiver simply holds the block out of idle.
// ----------------------------------------------------------------------------
module refcounted_compacting_allocator_core #(
  parameter int POOL_BYTES  = rca_pkg::PoolBytesDefault,
  parameter int MAX_OBJECTS = rca_pkg::MaxObjectsDefault
) (
  input logic clk,
  input logic rst,
  rca_req_if.sink req,
  rca_rsp_if.source rsp
);
  import rca_pkg::*;

  localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_OBJECTS + 1);
  localparam int BW = $clog2(POOL_BYTES + 1);

  typedef struct packed {
    logic [31:0] h;
    logic [BW-1:0] off;
    logic [BW-1:0] size;
    logic [15:0] rc;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_SRD    = 9'b000000100,
    S_SCMP   = 9'b000001000,
    S_CRD    = 9'b000010000,
    S_CWR    = 9'b000100000,
    S_INS    = 9'b001000000,
    S_SHIFT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  entry_t mem [MAX_OBJECTS];
  entry_t rd;
  logic [IW-1:0] raddr;
  logic re, we;
  logic re_next, we_next;
  logic [IW-1:0] waddr;
  entry_t wdata;

  req_t r;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [BW-1:0] bump, live, freed, pos;
  logic [31:0] nexth;
  logic half;
  logic shift_pend;
  rsp_t o;
  rsp_t rsp_word;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  // Half and the live totals are final once the word is shown.
  always_comb begin
    rsp_word = o;
    rsp_word.buffer_half = half;
    rsp_word.bytes_in_use = 17'(live);
    rsp_word.object_count = 7'(cnt);
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = rsp_word;

  logic [BW:0] size_w;
  assign size_w = {1'b0, r.alloc_size[BW-1:0]};
  logic size_bad;
  always_comb begin
    size_bad = (r.alloc_size == 17'd0) ||
               ({15'd0, r.alloc_size} > 32'(POOL_BYTES));
  end

  logic no_space;
  assign no_space = ({1'b0, live} + size_w > (BW+1)'(POOL_BYTES));
  logic hit;
  assign hit = (rd.h == r.handle);
  logic drop_all;
  assign drop_all = (r.command == CMD_DROP_REF) && (rd.rc == 16'd1 || rd.rc == 16'd0);

  always_comb begin
    re_next = (state == S_SRD) || (state == S_CRD) ||
              (state == S_SHIFT && !shift_pend && idx < cnt);
    we_next = (state == S_SCMP && !re && hit &&
               (r.command == CMD_ADD_REF || (r.command == CMD_DROP_REF && !drop_all))) ||
              (state == S_SHIFT && shift_pend && !re) ||
              (state == S_CWR && !re) ||
              (state == S_INS && !no_space);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      re <= 1'b0; we <= 1'b0;
      cnt <= '0; bump <= '0; live <= '0; freed <= '0;
      nexth <= 32'd1; half <= 1'b0; shift_pend <= 1'b0;
    end else begin
      re <= re_next;
      we <= we_next;
      unique case (state)
        S_IDLE: if (req.valid) begin
          r <= req.data;
          o <= '0;
          state <= S_DECODE;
        end
        S_DECODE: begin
          idx <= '0;
          pos <= '0;
          if (r.command == CMD_INSERT) begin
            if (size_bad) begin
              o.status <= ST_BAD_SIZE; state <= S_OUT;
            end else if (cnt >= CW'(MAX_OBJECTS)) begin
              o.status <= ST_FULL; state <= S_OUT;
            end else if (nexth == 32'd0) begin
              o.status <= ST_EXHAUSTED; state <= S_OUT;
            end else if ({1'b0, bump} + size_w > (BW+1)'(POOL_BYTES)) begin
              o.compacted <= 1'b1;
              o.freed_before_compaction <= 17'(freed);
              state <= (cnt == '0) ? S_INS : S_CRD;
              if (cnt == '0) begin
                bump <= '0; half <= ~half; freed <= '0;
              end
            end else begin
              state <= S_INS;
            end
          end else if (r.handle == 32'd0) begin
            o.status <= ST_NULL; state <= S_OUT;
          end else if (cnt == '0) begin
            o.status <= ST_NOT_FOUND; state <= S_OUT;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: begin
          raddr <= idx[IW-1:0]; state <= S_SCMP;
        end
        S_SCMP: if (!re) begin
          if (hit) begin
            o.start_offset <= 16'(rd.off);
            waddr <= idx[IW-1:0];
            if (r.command == CMD_ADD_REF) begin
              wdata <= '{h: rd.h, off: rd.off, size: rd.size,
                         rc: (rd.rc == 16'hFFFF) ? rd.rc : rd.rc + 16'd1};
              o.ref_count_now <= (rd.rc == 16'hFFFF) ? rd.rc : rd.rc + 16'd1;
              state <= S_OUT;
            end else if (drop_all) begin
              freed <= freed + rd.size;
              live <= live - rd.size;
              idx <= idx + 1'b1;
              shift_pend <= 1'b0;
              state <= S_SHIFT;
            end else if (r.command == CMD_DROP_REF) begin
              wdata <= '{h: rd.h, off: rd.off, size: rd.size, rc: rd.rc - 16'd1};
              o.ref_count_now <= rd.rc - 16'd1;
              state <= S_OUT;
            end else begin
              o.ref_count_now <= rd.rc;
              state <= S_OUT;
            end
          end else if (idx + 1'b1 >= cnt) begin
            o.status <= ST_NOT_FOUND; state <= S_OUT;
          end else begin
            idx <= idx + 1'b1; state <= S_SRD;
          end
        end
        S_SHIFT: begin
          // Move entry idx down to idx-1, one read then one write per entry.
          if (!shift_pend) begin
            if (idx >= cnt) begin
              cnt <= cnt - 1'b1; state <= S_OUT;
            end else begin
              raddr <= idx[IW-1:0]; shift_pend <= 1'b1;
            end
          end else if (!re) begin
            waddr <= IW'(idx - 1'b1); wdata <= rd;
            idx <= idx + 1'b1; shift_pend <= 1'b0;
          end
        end
        S_CRD: begin
          raddr <= idx[IW-1:0]; state <= S_CWR;
        end
        S_CWR: if (!re) begin
          waddr <= idx[IW-1:0];
          wdata <= '{h: rd.h, off: pos, size: rd.size, rc: rd.rc};
          pos <= pos + rd.size;
          if (idx + 1'b1 >= cnt) begin
            bump <= pos + rd.size; half <= ~half; freed <= '0;
            state <= S_INS;
          end else begin
            idx <= idx + 1'b1; state <= S_CRD;
          end
        end
        S_INS: begin
          if (no_space) begin
            o.status <= ST_NO_SPACE;
          end else begin
            waddr <= cnt[IW-1:0];
            wdata.h <= nexth; wdata.off <= bump;
            wdata.size <= size_w[BW-1:0]; wdata.rc <= 16'd1;
            o.new_handle <= nexth;
            o.start_offset <= 16'(bump);
            o.ref_count_now <= 16'd1;
            nexth <= nexth + 32'd1;
            cnt <= cnt + 1'b1;
            bump <= bump + size_w[BW-1:0];
            live <= live + size_w[BW-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_OBJECTS)) else $error("object count past table depth");
  a_live_max: assert property (@(posedge clk) disable iff (rst)
    {1'b0, live} <= (BW+1)'(POOL_BYTES)) else $error("live bytes past pool");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken while response pending");

endmodule
